// ===== design/gbf_pkg.sv =====
// Shared types and constants for the greedy box suppression filter.
// Used by every module of the block; depends on nothing.
package gbf_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int STAGE_LAST = 4;

    typedef struct packed {
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic [15:0]        in_w;
        logic [15:0]        in_h;
        logic [15:0]        in_score;
        logic               in_last;
    } box_in_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [15:0]        out_w;
        logic [15:0]        out_h;
        logic [15:0]        out_score;
        logic               out_last;
        logic               overflow;
    } box_out_t;

    typedef struct packed {
        logic               valid;
        logic               sup;
        logic [15:0]        score;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
    } cell_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_LEFT   = 2'd2
    } cell_op_t;

endpackage

// ===== design/gbf_cell.sv =====
// One cell of the sorted box chain: holds a box, inserts by score, shifts left.
// Depends on gbf_pkg.
module gbf_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  gbf_pkg::cell_op_t op,
    input  gbf_pkg::cell_t   new_box,
    input  gbf_pkg::cell_t   prev_data,
    input  gbf_pkg::cell_t   next_data,
    input  logic             take_prev,
    output logic             take,
    output gbf_pkg::cell_t   data
);

    gbf_pkg::cell_t data_reg;
    gbf_pkg::cell_t data_next;

    // The new box goes behind every stored box of equal or higher score.
    assign take = !data_reg.valid || (new_box.score > data_reg.score);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            gbf_pkg::OP_INSERT:
            begin
                if (take && !take_prev)
                begin
                    data_next = new_box;
                end
                else if (take)
                begin
                    data_next = prev_data;
                end
            end
            gbf_pkg::OP_LEFT:
            begin
                data_next = next_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== design/gbf_iou.sv =====
// Multi-step overlap test of one box against the kept box, by cross-multiply.
// Depends on gbf_pkg.
module gbf_iou (
    input  logic           clk,
    input  logic           load_k,
    input  gbf_pkg::cell_t k_box,
    input  logic           en,
    input  logic [2:0]     step,
    input  gbf_pkg::cell_t b_box,
    input  logic [15:0]    thr,
    output logic           hit
);

    logic signed [17:0] ka_x, ka_y, kb_x, kb_y, ke_x, ke_y, be_x, be_y;
    logic signed [17:0] x1, y1, x2, y2;
    logic signed [18:0] dx, dy;
    logic signed [17:0] kx_reg, ky_reg, kex_reg, key_reg;
    logic [31:0]        karea_reg;
    logic [15:0]        iw_reg, ih_reg;
    logic               ov_reg;
    logic [31:0]        barea_reg, inter_reg;
    logic [32:0]        uni_reg;
    logic [48:0]        prod_reg;

    always_ff @(posedge clk)
    begin
        if (load_k)
        begin
            kx_reg    <= {{2{k_box.x[15]}}, k_box.x};
            ky_reg    <= {{2{k_box.y[15]}}, k_box.y};
            kex_reg   <= {{2{k_box.x[15]}}, k_box.x} + $signed({2'b00, k_box.w});
            key_reg   <= {{2{k_box.y[15]}}, k_box.y} + $signed({2'b00, k_box.h});
            karea_reg <= k_box.w * k_box.h;
        end
    end

    assign ka_x = kx_reg;
    assign ka_y = ky_reg;
    assign ke_x = kex_reg;
    assign ke_y = key_reg;
    assign kb_x = {{2{b_box.x[15]}}, b_box.x};
    assign kb_y = {{2{b_box.y[15]}}, b_box.y};
    assign be_x = kb_x + $signed({2'b00, b_box.w});
    assign be_y = kb_y + $signed({2'b00, b_box.h});
    assign x1 = (ka_x > kb_x) ? ka_x : kb_x;
    assign y1 = (ka_y > kb_y) ? ka_y : kb_y;
    assign x2 = (ke_x < be_x) ? ke_x : be_x;
    assign y2 = (ke_y < be_y) ? ke_y : be_y;
    assign dx = {x2[17], x2} - {x1[17], x1};
    assign dy = {y2[17], y2} - {y1[17], y1};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (step)
                3'd0:
                begin
                    ov_reg    <= (dx > 19'sd0) && (dy > 19'sd0);
                    iw_reg    <= dx[15:0];
                    ih_reg    <= dy[15:0];
                    barea_reg <= b_box.w * b_box.h;
                end
                3'd1:
                begin
                    inter_reg <= iw_reg * ih_reg;
                end
                3'd2:
                begin
                    uni_reg <= {1'b0, karea_reg} + {1'b0, barea_reg} - {1'b0, inter_reg};
                end
                3'd3:
                begin
                    prod_reg <= thr * uni_reg;
                end
                default:
                begin
                    prod_reg <= prod_reg;
                end
            endcase
        end
    end

    assign hit = ov_reg && (uni_reg != 33'd0) && ({1'b0, inter_reg, 16'h0000} > {1'b0, prod_reg});

endmodule

// ===== design/greedy_nms_box_filter.sv =====
// Top level of the greedy box suppression filter: cell chain, overlap unit, control.
// Depends on gbf_pkg, gbf_cell and gbf_iou.

// Boxes are requested one per cycle while busy is low; each is inserted into a
// score-sorted chain of MAX_BOXES cells. The request with in_last set starts
// suppression and raises busy. The head box is popped each cycle between
// rotations; each kept box then rotates the whole chain once past a shared overlap
// unit, empty or suppressed cells passing without a test and live cells being held
// while the unit steps through its test. Results appear for a
// single cycle with result_valid and cannot be stalled; the last kept box comes
// out when the chain is empty, and busy falls in the same cycle.
module greedy_nms_box_filter #(
    parameter int MAX_BOXES = gbf_pkg::MAX_BOXES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gbf_pkg::box_in_t  box_in,
    output logic              result_valid,
    output gbf_pkg::box_out_t result,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);

    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int RW = $clog2(MAX_BOXES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_CMP  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [RW-1:0]     rot_reg, rot_next;
    logic [2:0]        stage_reg, stage_next;
    logic [15:0]       thr_reg;
    logic              pend_v_reg, pend_v_next;
    gbf_pkg::cell_t    pend_reg, pend_next;
    logic              res_v_reg, res_v_next;
    gbf_pkg::box_out_t res_reg, res_next;

    gbf_pkg::cell_op_t op;
    gbf_pkg::cell_t    new_box, feed;
    gbf_pkg::cell_t    data [MAX_BOXES];
    logic              take [MAX_BOXES];
    logic              load_k, hit;

    assign new_box.valid = 1'b1;
    assign new_box.sup   = 1'b0;
    assign new_box.score = box_in.in_score;
    assign new_box.x     = box_in.in_x;
    assign new_box.y     = box_in.in_y;
    assign new_box.w     = box_in.in_w;
    assign new_box.h     = box_in.in_h;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BOXES; gi++)
        begin : g_cell
            gbf_pkg::cell_t prev_d, next_d;
            logic           take_p;
            if (gi == 0)
            begin : g_head
                assign prev_d = new_box;
                assign take_p = 1'b0;
            end
            else
            begin : g_body
                assign prev_d = data[gi-1];
                assign take_p = take[gi-1];
            end
            if (gi == MAX_BOXES - 1)
            begin : g_tail
                assign next_d = feed;
            end
            else
            begin : g_mid
                assign next_d = data[gi+1];
            end
            gbf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op),
                .new_box   (new_box),
                .prev_data (prev_d),
                .next_data (next_d),
                .take_prev (take_p),
                .take      (take[gi]),
                .data      (data[gi])
            );
        end
    endgenerate

    gbf_iou u_iou (
        .clk    (clk),
        .load_k (load_k),
        .k_box  (data[0]),
        .en     (state_reg == ST_CMP),
        .step   (stage_reg),
        .b_box  (data[0]),
        .thr    (thr_reg),
        .hit    (hit)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        rot_next    = rot_reg;
        stage_next  = stage_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        res_v_next  = 1'b0;
        res_next    = res_reg;
        op          = gbf_pkg::OP_HOLD;
        feed        = data[0];
        load_k      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < CW'(MAX_BOXES))
                    begin
                        op         = gbf_pkg::OP_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (box_in.in_last)
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                feed.valid = 1'b0;
                if (!data[0].valid)
                begin
                    if (pend_v_reg)
                    begin
                        res_v_next         = 1'b1;
                        res_next.out_x     = pend_reg.x;
                        res_next.out_y     = pend_reg.y;
                        res_next.out_w     = pend_reg.w;
                        res_next.out_h     = pend_reg.h;
                        res_next.out_score = pend_reg.score;
                        res_next.out_last  = 1'b1;
                        res_next.overflow  = ovf_reg;
                    end
                    pend_v_next = 1'b0;
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    op = gbf_pkg::OP_LEFT;
                    if (!data[0].sup)
                    begin
                        if (pend_v_reg)
                        begin
                            res_v_next         = 1'b1;
                            res_next.out_x     = pend_reg.x;
                            res_next.out_y     = pend_reg.y;
                            res_next.out_w     = pend_reg.w;
                            res_next.out_h     = pend_reg.h;
                            res_next.out_score = pend_reg.score;
                            res_next.out_last  = 1'b0;
                            res_next.overflow  = ovf_reg;
                        end
                        pend_v_next = 1'b1;
                        pend_next   = data[0];
                        load_k      = 1'b1;
                        rot_next    = '0;
                        stage_next  = '0;
                        state_next  = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (!data[0].valid || data[0].sup || (stage_reg == 3'(gbf_pkg::STAGE_LAST)))
                begin
                    op         = gbf_pkg::OP_LEFT;
                    feed.sup   = data[0].sup
                                 || (data[0].valid
                                     && (stage_reg == 3'(gbf_pkg::STAGE_LAST)) && hit);
                    stage_next = '0;
                    if (rot_reg == RW'(MAX_BOXES - 1))
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        rot_next = rot_reg + RW'(1);
                    end
                end
                else
                begin
                    stage_next = stage_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            rot_reg    <= '0;
            stage_reg  <= '0;
            pend_v_reg <= 1'b0;
            res_v_reg  <= 1'b0;
            thr_reg    <= 16'h8000;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            rot_reg    <= rot_next;
            stage_reg  <= stage_next;
            pend_v_reg <= pend_v_next;
            res_v_reg  <= res_v_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_v_reg;
    assign result       = res_reg;

endmodule
